// ===== hdl/pbs_pkg.sv =====
// Shared types and constants of the parallel bus slave.
// No dependencies; every other file imports this package.
package pbs_pkg;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_BUS  = 1'b1;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_WRITE = 2'd1;
    localparam logic [1:0] PH_READ  = 2'd2;

    typedef struct packed {
        logic       action;
        logic [7:0] push_byte;
        logic       cs_n;
        logic       wr_n;
        logic       rd_n;
        logic [7:0] bus_byte;
    } t_item;

    typedef struct packed {
        logic       ready_n;
        logic       pending_n;
        logic       drive_enable;
        logic [7:0] drive_byte;
        logic       received_valid;
        logic [7:0] received_byte;
        logic       push_dropped;
    } t_result;

    // Result fields known at the end of the control stage; the popped byte comes later.
    typedef struct packed {
        logic       ready_n;
        logic       pending_n;
        logic       drive_enable;
        logic       received_valid;
        logic [7:0] received_byte;
        logic       push_dropped;
        logic       pop;
    } t_stage;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== hdl/pbs_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
// Depends on pbs_pkg for the payload types.
interface pbs_in_if import pbs_pkg::*; ();
    logic  valid;
    logic  ready;
    t_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pbs_out_if import pbs_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/pbs_txq.sv =====
// Transmit byte queue: circular buffer memory with head/tail pointers and a fill count.
// Depends on pbs_pkg for the queue control and status structs.
module pbs_txq import pbs_pkg::*; #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_ctl     i_ctl,
    input  logic [7:0] i_push_byte,
    output t_q_stat    o_stat,
    output logic [7:0] o_rd_byte
);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    logic [7:0]    r_mem [QUEUE_DEPTH];
    logic [7:0]    r_rd_byte;
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctl.push) begin
            n_tail  = (r_tail == LAST_PTR) ? '0 : r_tail + PW'(1);
            n_count = r_count + CW'(1);
        end
        if (i_ctl.pop) begin
            n_head  = (r_head == LAST_PTR) ? '0 : r_head + PW'(1);
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_tail] <= i_push_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_rd_byte <= r_mem[r_head];
        end
    end

    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);
    assign o_rd_byte    = r_rd_byte;

endmodule

// ===== hdl/pbs_ctrl.sv =====
// Bus handshake control: transfer phase, ready and data-pending lines, queue push/pop.
// Depends on pbs_pkg for item, stage and queue types.
module pbs_ctrl import pbs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_item   i_item,
    input  t_q_stat i_q_stat,
    output t_q_ctl  o_q_ctl,
    output t_stage  o_res
);
    logic [1:0] r_phase, n_phase;
    logic       r_ready, n_ready;
    logic       r_pending, n_pending;
    logic       push, pop, rx, dropped, idle;

    always_comb begin
        n_phase   = r_phase;
        n_ready   = r_ready;
        n_pending = r_pending;
        push      = 1'b0;
        pop       = 1'b0;
        rx        = 1'b0;
        dropped   = 1'b0;
        idle      = (r_phase != PH_WRITE) && (r_phase != PH_READ);
        if (i_item.action == ACT_PUSH) begin
            dropped   = i_q_stat.full;
            push      = !i_q_stat.full;
            n_pending = 1'b0;
        end else if (idle) begin
            n_phase = PH_IDLE;
            if (!i_item.cs_n) begin
                priority if (!i_item.wr_n) begin
                    rx      = 1'b1;
                    n_ready = 1'b1;
                    n_phase = PH_WRITE;
                end else if (!i_item.rd_n && !i_q_stat.empty) begin
                    pop     = 1'b1;
                    n_ready = 1'b1;
                    n_phase = PH_READ;
                end
            end
        end else if (i_item.cs_n) begin
            // End of transfer: release ready, raise pending after a read that drained the queue
            if (r_phase == PH_READ && i_q_stat.empty) begin
                n_pending = 1'b1;
            end
            n_ready = 1'b0;
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_ready   <= 1'b0;
            r_pending <= 1'b1;
        end else if (i_adv) begin
            r_phase   <= n_phase;
            r_ready   <= n_ready;
            r_pending <= n_pending;
        end
    end

    assign o_q_ctl.push = i_adv && push;
    assign o_q_ctl.pop  = i_adv && pop;

    assign o_res.ready_n        = n_ready;
    assign o_res.pending_n      = n_pending;
    assign o_res.drive_enable   = (n_phase == PH_READ);
    assign o_res.received_valid = rx;
    assign o_res.received_byte  = rx ? i_item.bus_byte : 8'd0;
    assign o_res.push_dropped   = dropped;
    assign o_res.pop            = pop;

endmodule

// ===== hdl/parallel_bus_slave_with_tx_fifo.sv =====
// Byte-wide parallel bus slave with a transmit queue of QUEUE_DEPTH bytes. Each input item is a
// software push or one sample of the host bus lines and yields exactly one result item. An item
// is taken in every cycle while results are consumed: it passes an input register, the control
// stage (phase, ready/pending lines, queue pointers and the queue memory access) and the result
// register, which holds the result item until it is consumed. The popped byte comes
// from the queue memory's registered read port, aligned with the result register.
module parallel_bus_slave_with_tx_fifo import pbs_pkg::*; #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pbs_in_if.sink       i_in,
    pbs_out_if.source    o_out
);
    logic       r_s1_v;
    t_item      r_s1;
    logic       r_s2_v;
    t_stage     r_s2;
    logic [7:0] r_drv_byte;
    logic       s2_take, adv;
    t_q_ctl     q_ctl;
    t_q_stat    q_stat;
    t_stage     stage_res;
    logic [7:0] rd_byte;
    logic [7:0] cur_drv;

    assign s2_take    = !r_s2_v || o_out.ready;
    assign adv        = r_s1_v && s2_take;
    assign i_in.ready = !r_s1_v || s2_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_s1_v <= 1'b1;
            end else if (adv) begin
                r_s1_v <= 1'b0;
            end
            if (adv) begin
                r_s2_v <= 1'b1;
            end else if (o_out.ready) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1 <= i_in.data;
        end
        if (adv) begin
            r_s2 <= stage_res;
        end
        // Hold the popped byte for later items of the same read transfer
        if (r_s2_v && o_out.ready && r_s2.pop) begin
            r_drv_byte <= rd_byte;
        end
    end

    pbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (r_s1),
        .i_q_stat (q_stat),
        .o_q_ctl  (q_ctl),
        .o_res    (stage_res)
    );

    pbs_txq #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_txq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (q_ctl),
        .i_push_byte (r_s1.push_byte),
        .o_stat      (q_stat),
        .o_rd_byte   (rd_byte)
    );

    assign cur_drv = r_s2.pop ? rd_byte : r_drv_byte;

    assign o_out.valid               = r_s2_v;
    assign o_out.data.ready_n        = r_s2.ready_n;
    assign o_out.data.pending_n      = r_s2.pending_n;
    assign o_out.data.drive_enable   = r_s2.drive_enable;
    assign o_out.data.drive_byte     = r_s2.drive_enable ? cur_drv : 8'd0;
    assign o_out.data.received_valid = r_s2.received_valid;
    assign o_out.data.received_byte  = r_s2.received_byte;
    assign o_out.data.push_dropped   = r_s2.push_dropped;

    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_ctl.push && q_ctl.pop))
        else $error("queue push and pop in the same cycle");

    a_drive_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && r_s2.drive_enable) |-> r_s2.ready_n)
        else $error("bus driven while ready is not acknowledged");

    a_rx_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && r_s2.received_valid) |-> !r_s2.drive_enable)
        else $error("byte captured during a read transfer");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_ctl.pop |-> !q_stat.empty)
        else $error("pop from an empty queue");

endmodule

// ===== dv/tb_parallel_bus_slave_with_tx_fifo.sv =====
// Testbench for the parallel bus slave: directed host transfers, a queue fill/overflow/drain
// pass and random bus traffic, all checked against an in-bench model of the slave.
// Depends on pbs_pkg, pbs_if and the parallel_bus_slave_with_tx_fifo RTL.
module tb_parallel_bus_slave_with_tx_fifo;
    import pbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH      = 64;
    localparam int ITEM_TARGET = 470;
    localparam int DRAIN_WAIT  = 20;

    typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE} t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    pbs_in_if  in_ch ();
    pbs_out_if out_ch ();

    parallel_bus_slave_with_tx_fifo #(.QUEUE_DEPTH(QDEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Slave model state
    logic [1:0] m_phase;
    logic [7:0] m_queue [QDEPTH];
    int         m_head;
    int         m_tail;
    int         m_fill;
    logic [7:0] m_driven;
    logic       m_ready_n;
    logic       m_pending_n;

    t_result expected_results [$];

    int n_sent;
    int n_checked;
    int n_errors;
    int n_captured;
    int n_popped;
    int n_dropped;
    int burst_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("timeout: %0d items sent, %0d results still expected",
                 n_sent, expected_results.size());
        $display("tb_parallel_bus_slave_with_tx_fifo: done, errors");
        $finish;
    end

    function automatic int next_slot(int p);
        return (p >= QDEPTH - 1) ? 0 : p + 1;
    endfunction

    task automatic reset_model();
        foreach (m_queue[i]) m_queue[i] = 8'h00;
        m_phase     = PH_IDLE;
        m_head      = 0;
        m_tail      = 0;
        m_fill      = 0;
        m_driven    = 8'h00;
        m_ready_n   = 1'b0;
        m_pending_n = 1'b1;
    endtask

    // Advance the model by one item and return the result it owes.
    function automatic t_result predict_bus_slave(t_item it);
        t_result r;
        r = '0;
        if (m_phase != PH_IDLE && m_phase != PH_WRITE && m_phase != PH_READ)
            m_phase = PH_IDLE;

        if (it.action == ACT_PUSH) begin
            if (m_fill >= QDEPTH) begin
                r.push_dropped = 1'b1;
                n_dropped++;
            end else begin
                m_queue[m_tail] = it.push_byte;
                m_tail = next_slot(m_tail);
                m_fill++;
            end
            if (m_fill > 0)
                m_pending_n = 1'b0;
        end else if (m_phase == PH_IDLE) begin
            if (!it.cs_n) begin
                if (!it.wr_n) begin
                    r.received_valid = 1'b1;
                    r.received_byte  = it.bus_byte;
                    m_ready_n = 1'b1;
                    m_phase   = PH_WRITE;
                    n_captured++;
                end else if (!it.rd_n && m_fill > 0) begin
                    m_driven  = m_queue[m_head];
                    m_head    = next_slot(m_head);
                    m_fill--;
                    m_ready_n = 1'b1;
                    m_phase   = PH_READ;
                    n_popped++;
                end
            end
        end else if (it.cs_n) begin
            if (m_phase == PH_READ && m_fill == 0)
                m_pending_n = 1'b1;
            m_ready_n = 1'b0;
            m_phase   = PH_IDLE;
        end

        r.ready_n      = m_ready_n;
        r.pending_n    = m_pending_n;
        r.drive_enable = (m_phase == PH_READ);
        r.drive_byte   = (m_phase == PH_READ) ? m_driven : 8'h00;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                      n_checked, name, got, want));
    endtask

    // Result checker: sample accepted results at the rising edge.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got = out_ch.data;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                          n_checked));
            end else begin
                want = expected_results.pop_front();
                compare_field("ready_n",        8'(got.ready_n),        8'(want.ready_n));
                compare_field("pending_n",      8'(got.pending_n),      8'(want.pending_n));
                compare_field("drive_enable",   8'(got.drive_enable),   8'(want.drive_enable));
                compare_field("drive_byte",     got.drive_byte,         want.drive_byte);
                compare_field("received_valid", 8'(got.received_valid),
                              8'(want.received_valid));
                compare_field("received_byte",  got.received_byte,      want.received_byte);
                compare_field("push_dropped",   8'(got.push_dropped),   8'(want.push_dropped));
            end
            n_checked++;
        end
    end

    // Result receiver: stall on segments of varying style.
    initial begin
        t_rx_mode mode;
        int seg_left;
        int tick;
        out_ch.ready = 1'b0;
        mode     = RX_FREE;
        seg_left = 0;
        tick     = 0;
        forever begin
            @(negedge i_clk);
            if (seg_left == 0) begin
                seg_left = $urandom_range(60, 15);
                mode     = t_rx_mode'($urandom_range(2, 0));
            end
            seg_left--;
            tick++;
            case (mode)
                RX_FREE:   out_ch.ready <= 1'b1;
                RX_RANDOM: out_ch.ready <= ($urandom_range(99, 0) < 60);
                default:   out_ch.ready <= (tick % 4 == 0);
            endcase
        end
    end

    function automatic logic rand_bit();
        return 1'($urandom_range(1, 0));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255, 0));
    endfunction

    function automatic t_item make_item(logic act, logic [7:0] pb, logic cs, logic wr,
                                        logic rd, logic [7:0] bb);
        t_item it;
        it.action    = act;
        it.push_byte = pb;
        it.cs_n      = cs;
        it.wr_n      = wr;
        it.rd_n      = rd;
        it.bus_byte  = bb;
        return it;
    endfunction

    function automatic t_item random_item();
        return make_item(rand_bit(), rand_byte(), rand_bit(), rand_bit(), rand_bit(),
                         rand_byte());
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
    endtask

    // Send one item; the sender works in bursts with random gaps between them.
    task automatic send_item(t_item it);
        if (burst_left == 0) begin
            if ($urandom_range(3, 0) != 0)
                idle_cycles($urandom_range(6, 1));
            burst_left = $urandom_range(40, 1);
        end
        burst_left--;
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        expected_results.push_back(predict_bus_slave(it));
        n_sent++;
    endtask

    task automatic push_item(logic [7:0] b);
        send_item(make_item(ACT_PUSH, b, rand_bit(), rand_bit(), rand_bit(), rand_byte()));
    endtask

    task automatic bus_sample(logic cs, logic wr, logic rd, logic [7:0] b);
        send_item(make_item(ACT_BUS, rand_byte(), cs, wr, rd, b));
    endtask

    // Hold chip select low for a few samples with stray strobes and pushes, then release.
    task automatic hold_and_release();
        repeat ($urandom_range(3, 0)) begin
            if ($urandom_range(3, 0) == 0)
                push_item(rand_byte());
            else
                bus_sample(1'b0, rand_bit(), rand_bit(), rand_byte());
        end
        bus_sample(1'b1, rand_bit(), rand_bit(), rand_byte());
    endtask

    task automatic host_write_txn(logic [7:0] b);
        bus_sample(1'b0, 1'b0, rand_bit(), b);
        hold_and_release();
    endtask

    task automatic host_read_txn();
        bus_sample(1'b0, 1'b1, 1'b0, rand_byte());
        hold_and_release();
    endtask

    task automatic test_host_write();
        bus_sample(1'b0, 1'b0, 1'b1, 8'hFF);
        bus_sample(1'b0, 1'b0, 1'b0, 8'h12);   // ignored: transfer still open
        bus_sample(1'b0, 1'b1, 1'b0, 8'h34);
        bus_sample(1'b1, 1'b0, 1'b0, 8'h56);   // chip select high closes it
        bus_sample(1'b0, 1'b0, 1'b0, 8'h00);   // both strobes low: write wins
        bus_sample(1'b1, 1'b1, 1'b1, 8'hFF);
    endtask

    task automatic test_read_empty();
        bus_sample(1'b0, 1'b1, 1'b0, 8'h5A);
        bus_sample(1'b1, 1'b1, 1'b1, 8'h00);
    endtask

    task automatic test_push_and_read();
        push_item(8'h00);
        push_item(8'hFF);
        bus_sample(1'b0, 1'b1, 1'b0, 8'h00);
        push_item(8'hA5);                       // push while the read is open
        bus_sample(1'b0, 1'b0, 1'b0, 8'h77);
        bus_sample(1'b1, 1'b1, 1'b1, 8'h00);
        bus_sample(1'b0, 1'b1, 1'b0, 8'hFF);
        bus_sample(1'b1, 1'b0, 1'b1, 8'hFF);
        bus_sample(1'b0, 1'b1, 1'b0, 8'h00);
        bus_sample(1'b1, 1'b1, 1'b0, 8'h00);   // queue empty: pending goes high
    endtask

    task automatic test_queue_full();
        while (m_fill < QDEPTH)
            push_item(rand_byte());
        repeat (3) push_item(rand_byte());
        repeat (2) host_read_txn();
        push_item(rand_byte());
        while (m_fill > 0)
            host_read_txn();
    endtask

    task automatic test_random_traffic();
        int pick;
        while (n_sent < ITEM_TARGET) begin
            pick = $urandom_range(99, 0);
            if (pick < 25) begin
                repeat ($urandom_range(4, 1)) push_item(rand_byte());
            end else if (pick < 50) begin
                host_write_txn(rand_byte());
            end else if (pick < 80) begin
                host_read_txn();
            end else if (pick < 90) begin
                repeat ($urandom_range(3, 1)) send_item(random_item());
            end else if (pick < 97) begin
                repeat ($urandom_range(16, 4)) host_read_txn();
            end else begin
                while (m_fill < QDEPTH)
                    push_item(rand_byte());
                push_item(rand_byte());
            end
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        i_rst_n     = 1'b0;
        n_sent      = 0;
        n_checked   = 0;
        n_errors    = 0;
        n_captured  = 0;
        n_popped    = 0;
        n_dropped   = 0;
        burst_left  = 0;
        reset_model();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_host_write();
        test_read_empty();
        test_push_and_read();
        test_queue_full();
        test_random_traffic();

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d items: %0d host writes captured, %0d bytes read out, "
                 , n_sent, n_captured, n_popped);
        $display("%0d full-queue pushes refused, %0d results checked", n_dropped, n_checked);
        if (n_errors == 0)
            $display("tb_parallel_bus_slave_with_tx_fifo: done, clean");
        else
            $display("tb_parallel_bus_slave_with_tx_fifo: done, errors");
        $finish;
    end

endmodule
